// File: hw/rtl/aqvr_pkg.sv
// ----------------------------------------------------------------------------
// aqvr_pkg
// Shared types and constants for the queue with value removal: request
// kinds, status codes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package aqvr_pkg;

  localparam int WORD_W = 32;
  localparam int CFG_W  = 5;
  localparam int OCC_W  = 5;
  localparam int KIND_W = 2;
  localparam int STS_W  = 2;

  localparam logic [CFG_W-1:0]  CAP_RESET   = CFG_W'(16);
  localparam logic [WORD_W-1:0] EMPTY_FRONT = {WORD_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_kind_t;

  typedef enum logic [STS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/aqvr_ifs.sv
// ----------------------------------------------------------------------------
// aqvr request and response channels
// Valid/ready channels for the queue requests and the per-request results.
// ----------------------------------------------------------------------------
`default_nettype none

interface aqvr_req_if;
  import aqvr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        req_type;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface aqvr_rsp_if;
  import aqvr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STS_W-1:0]         status;
  logic signed [WORD_W-1:0] front_value;
  logic [OCC_W-1:0]         occupancy;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output status, output front_value, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input front_value, input occupancy,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/array_queue_with_value_removal.sv
// ----------------------------------------------------------------------------
// array_queue_with_value_removal
// Bounded FIFO of signed words with enqueue, dequeue and remove-all-equal.
// ----------------------------------------------------------------------------
// The queue lives in a circular single-write, single-read memory of DEPTH
// words; one request is worked at a time and each gives one result on rsp.
// Enqueue and rejected or unused requests go from S_IDLE straight to S_DONE,
// a dequeue passes S_FETCH and S_LOAD to read the new front (skipped when it
// leaves the queue empty), and a remove runs S_REMOVE, where the memory
// read port sweeps the stored entries one per cycle while kept entries are
// written back in order. A new request is taken once the previous result
// is loaded into the output register, even while that result still waits
// for a transfer.
`default_nettype none

module array_queue_with_value_removal #(
  parameter int DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [aqvr_pkg::CFG_W-1:0]  cfg_wdata,
  aqvr_req_if.sink                         req,
  aqvr_rsp_if.source                       rsp
);
  import aqvr_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SUM_W = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_REMOVE,
    S_DONE
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  cap_reg;
  logic [AW-1:0]     head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_i;
  logic [CNT_W-1:0]  kept;
  logic              pend;
  logic [WORD_W-1:0] front;
  logic [WORD_W-1:0] rm_val;
  status_t           sts;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic [EXT_W-1:0]  cap_eff;
  logic [EXT_W-1:0]  count_ext;
  logic              full;
  logic              accept;
  logic              keep_hit;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // effective capacity clamped to 1..DEPTH
  always_comb begin
    cap_eff = EXT_W'(cap_reg);
    if (cap_eff == '0) begin
      cap_eff = EXT_W'(1);
    end else if (cap_eff > EXT_W'(DEPTH)) begin
      cap_eff = EXT_W'(DEPTH);
    end
  end

  assign count_ext = EXT_W'(count);
  assign full      = (count_ext >= cap_eff);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign keep_hit  = pend && (rdata != rm_val);

  assign mem_raddr = wrap_add(head, rd_i);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wrap_add(head, count);
    mem_wdata = req.value;
    if (state == S_REMOVE) begin
      mem_waddr = wrap_add(head, kept);
      mem_wdata = rdata;
      mem_we    = keep_hit;
    end else if (accept && (req.req_type == REQ_ENQ) && !full) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rd_i      <= '0;
      kept      <= '0;
      pend      <= 1'b0;
      sts       <= ST_DONE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_i   <= '0;
            kept   <= '0;
            pend   <= 1'b0;
            rm_val <= req.value;
            case (req.req_type)
              REQ_ENQ: begin
                state <= S_DONE;
                if (full) begin
                  sts <= ST_FULL;
                end else begin
                  sts <= ST_DONE;
                  if (count == '0) begin
                    front <= req.value;
                  end
                  count <= count + CNT_W'(1);
                end
              end
              REQ_DEQ: begin
                if (count == '0) begin
                  sts   <= ST_EMPTY;
                  state <= S_DONE;
                end else begin
                  sts   <= ST_DONE;
                  head  <= wrap_add(head, CNT_W'(1));
                  count <= count - CNT_W'(1);
                  state <= (count != CNT_W'(1)) ? S_FETCH : S_DONE;
                end
              end
              REQ_REMOVE: begin
                sts   <= ST_DONE;
                state <= S_REMOVE;
              end
              default: begin
                sts   <= ST_DONE;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          front <= rdata;
          state <= S_DONE;
        end
        S_REMOVE: begin
          if (keep_hit) begin
            if (kept == '0) begin
              front <= rdata;
            end
            kept <= kept + CNT_W'(1);
          end
          if (rd_i < count) begin
            rd_i <= rd_i + CNT_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= kept;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= sts;
            rsp.front_value <= (count == '0) ? EMPTY_FRONT : front;
            rsp.occupancy   <= count_ext[OCC_W-1:0];
            rsp.is_empty    <= (count == '0);
            rsp.is_full     <= full;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/aqvr_checker.sv
// ----------------------------------------------------------------------------
// aqvr_checker
// Port-level checks on the result channel of the queue with value removal.
// ----------------------------------------------------------------------------
`default_nettype none

module aqvr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [aqvr_pkg::STS_W-1:0]    rsp_status,
  input wire logic [aqvr_pkg::WORD_W-1:0]   rsp_front_value,
  input wire logic [aqvr_pkg::OCC_W-1:0]    rsp_occupancy,
  input wire logic                          rsp_is_empty,
  input wire logic                          rsp_is_full
);
  import aqvr_pkg::*;

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_is_empty) |-> (rsp_front_value == EMPTY_FRONT))
    else $error("empty queue reports a front value other than -1");

  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_status != ST_FULL) || rsp_is_full) &&
                  ((rsp_status != ST_EMPTY) || rsp_is_empty))
    else $error("rejection status without matching flag");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_front_value)))
    else $error("stalled result dropped or changed");

endmodule

bind array_queue_with_value_removal aqvr_checker u_aqvr_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_front_value (rsp.front_value),
  .rsp_occupancy   (rsp.occupancy),
  .rsp_is_empty    (rsp.is_empty),
  .rsp_is_full     (rsp.is_full)
);

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks array_queue_with_value_removal against a queue-based predictor.
// Directed requests cover the empty and full cases, the extreme words, the
// unused request kind and a capacity lowered below occupancy. Random phases
// then sweep several capacity settings with both channels stalling at random in all but one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import aqvr_pkg::*;

  localparam int QDEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
  } req_item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] front;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
    logic              is_full;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  aqvr_req_if req_ch ();
  aqvr_rsp_if rsp_ch ();

  array_queue_with_value_removal #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  req_item_t         stim_q[$];
  queue_result_t     expect_q[$];
  logic [WORD_W-1:0] held[$];
  logic [CFG_W-1:0]  cap_val = CAP_RESET;
  logic              calm = 1'b0;
  int                n_queued = 0;
  int                n_checked = 0;
  int                n_mismatch = 0;
  int                cycle_cnt = 0;

  always #5 clk = ~clk;

  function automatic queue_result_t apply_request(logic [KIND_W-1:0] kind,
                                                  logic [WORD_W-1:0] word);
    queue_result_t     r;
    logic [WORD_W-1:0] kept[$];
    int                lim;
    lim = (cap_val == 0) ? 1 : ((cap_val > QDEPTH) ? QDEPTH : int'(cap_val));
    r.status = ST_DONE;
    case (kind)
      REQ_ENQ: begin
        if (held.size() >= lim) r.status = ST_FULL;
        else held.push_back(word);
      end
      REQ_DEQ: begin
        if (held.size() == 0) r.status = ST_EMPTY;
        else void'(held.pop_front());
      end
      REQ_REMOVE: begin
        foreach (held[i]) if (held[i] !== word) kept.push_back(held[i]);
        held = kept;
      end
      default: ;
    endcase
    r.front     = (held.size() == 0) ? EMPTY_FRONT : held[0];
    r.occupancy = OCC_W'(held.size());
    r.is_empty  = (held.size() == 0);
    r.is_full   = (held.size() >= lim);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin : drive
    req_item_t nxt;
    if (rst) begin
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_ENQ;
      req_ch.value    <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expect_q.push_back(apply_request(req_ch.req_type, req_ch.value));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (stim_q.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
          nxt = stim_q.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= nxt.kind;
          req_ch.value    <= nxt.word;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    queue_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expect_q.size() == 0) begin
          if (n_mismatch < 10)
            $display("unexpected result transfer: status %0d front %h occupancy %0d",
                     rsp_ch.status, rsp_ch.front_value, rsp_ch.occupancy);
          n_mismatch++;
        end else begin
          want = expect_q.pop_front();
          n_checked++;
          if (rsp_ch.status !== want.status || rsp_ch.front_value !== want.front ||
              rsp_ch.occupancy !== want.occupancy || rsp_ch.is_empty !== want.is_empty ||
              rsp_ch.is_full !== want.is_full) begin
            if (n_mismatch < 10) begin
              $display("result %0d expected: status %0d front %h occ %0d empty %b full %b",
                       n_checked, want.status, want.front, want.occupancy,
                       want.is_empty, want.is_full);
              $display("result %0d actual:   status %0d front %h occ %0d empty %b full %b",
                       n_checked, rsp_ch.status, rsp_ch.front_value, rsp_ch.occupancy,
                       rsp_ch.is_empty, rsp_ch.is_full);
            end
            n_mismatch++;
          end
        end
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word);
    stim_q.push_back('{kind, word});
    n_queued++;
  endtask

  task automatic drain();
    while (n_checked < n_queued) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cap_val = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int enq_pct);
    logic [WORD_W-1:0] pool[4];
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    int                r;
    pool[0] = $urandom();
    pool[1] = $urandom();
    pool[2] = 32'hFFFF_FFFF;
    pool[3] = 32'h8000_0000;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < enq_pct) kind = REQ_ENQ;
      else if (r < enq_pct + (95 - enq_pct) / 2) kind = REQ_DEQ;
      else if (r < 95) kind = REQ_REMOVE;
      else kind = REQ_UNUSED;
      // repeated words make removals hit several entries
      if ($urandom_range(99) < 60) word = pool[$urandom_range(3)];
      else word = $urandom();
      push_item(kind, word);
    end
  endtask

  initial begin
    int caps[8]    = '{16, 1, 31, 5, 0, 9, 2, 16};
    int enq_pcts[8] = '{70, 50, 65, 45, 40, 55, 50, 35};
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset capacity, empty cases and extreme words
    push_item(REQ_DEQ, 32'h0);
    push_item(REQ_REMOVE, 32'h0);
    push_item(REQ_UNUSED, 32'hFFFF_FFFF);
    push_item(REQ_ENQ, 32'h7FFF_FFFF);
    push_item(REQ_ENQ, 32'h8000_0000);
    push_item(REQ_ENQ, 32'hFFFF_FFFF);
    push_item(REQ_ENQ, 32'hFFFF_FFFF);
    push_item(REQ_ENQ, 32'h0);
    push_item(REQ_REMOVE, 32'd12345);
    push_item(REQ_REMOVE, 32'hFFFF_FFFF);
    push_item(REQ_UNUSED, 32'h5555_AAAA);
    push_item(REQ_DEQ, 32'hAAAA_5555);
    push_item(REQ_DEQ, 32'h0);
    push_item(REQ_REMOVE, 32'h0);
    drain();

    // zero capacity acts as one
    write_capacity(5'd0);
    push_item(REQ_ENQ, 32'd1);
    push_item(REQ_ENQ, 32'd2);
    push_item(REQ_DEQ, 32'h0);
    push_item(REQ_DEQ, 32'h0);
    drain();

    // capacity lowered below occupancy
    write_capacity(5'd16);
    push_item(REQ_ENQ, 32'd10);
    push_item(REQ_ENQ, 32'd20);
    push_item(REQ_ENQ, 32'd30);
    push_item(REQ_ENQ, 32'd40);
    drain();
    write_capacity(5'd2);
    push_item(REQ_ENQ, 32'd50);
    push_item(REQ_DEQ, 32'h0);
    push_item(REQ_DEQ, 32'h0);
    push_item(REQ_DEQ, 32'h0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_capacity(CFG_W'(caps[p]));
      calm = (p == 2);
      random_phase(50, enq_pcts[p]);
      drain();
    end
    calm = 1'b0;

    repeat (40) @(posedge clk);
    if (n_mismatch == 0 && expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/aqvr_pkg.sv
hw/rtl/aqvr_ifs.sv
hw/rtl/array_queue_with_value_removal.sv
hw/rtl/aqvr_checker.sv
tb/testbench.sv
